// ===== rtl/core/rpc_pkg.sv =====
// ----------------------------------------------------------------------------
// rpc_pkg: shared types and constants of the red pixel centroid block
// Field widths, register reset values, register indexes and the command and
// status structs that join the controller and the datapath.
// ----------------------------------------------------------------------------
`default_nettype none

package rpc_pkg;

  // Pixel fields.
  localparam int COORD_W = 10;
  localparam int CHAN_W  = 8;

  // Largest frame the accumulators are sized for.
  localparam int MAX_WIDTH  = 1024;
  localparam int MAX_HEIGHT = 1024;
  localparam int COUNT_CAP  = MAX_WIDTH * MAX_HEIGHT;

  // Accumulator and divider widths.
  localparam int CNT_W  = $clog2(COUNT_CAP + 1);
  localparam int SUM_W  = COORD_W + $clog2(COUNT_CAP);
  localparam int DIV_W  = CNT_W + COORD_W - 1;
  localparam int DIV_STEPS = COORD_W;
  localparam int STEP_W = $clog2(DIV_STEPS);

  // Configuration registers.
  localparam int MARGIN_W   = 8;
  localparam int SIZE_W     = 11;
  localparam int WIN_W      = SIZE_W + 1;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 11;

  localparam logic [CHAN_W-1:0]   RED_MIN_RST   = 8'd150;
  localparam logic [CHAN_W-1:0]   GREEN_MAX_RST = 8'd50;
  localparam logic [CHAN_W-1:0]   BLUE_MAX_RST  = 8'd50;
  localparam logic [MARGIN_W-1:0] MARGIN_RST    = 8'd5;
  localparam logic [SIZE_W-1:0]   WIDTH_RST     = 11'd640;
  localparam logic [SIZE_W-1:0]   HEIGHT_RST    = 11'd480;

  // Recolour values of a matched pixel.
  localparam logic [CHAN_W-1:0] CHAN_FULL = 8'hFF;
  localparam logic [CHAN_W-1:0] CHAN_NONE = 8'h00;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_RED_MIN       = 3'd0,
    REG_GREEN_MAX     = 3'd1,
    REG_BLUE_MAX      = 3'd2,
    REG_MARKER_MARGIN = 3'd3,
    REG_FRAME_WIDTH   = 3'd4,
    REG_FRAME_HEIGHT  = 3'd5
  } cfg_idx_e;

  typedef struct packed {
    logic [COORD_W-1:0] pixel_x;
    logic [COORD_W-1:0] pixel_y;
    logic [CHAN_W-1:0]  in_blue;
    logic [CHAN_W-1:0]  in_green;
    logic [CHAN_W-1:0]  in_red;
    logic               frame_last;
  } pix_t;

  typedef struct packed {
    logic [CHAN_W-1:0]  out_blue;
    logic [CHAN_W-1:0]  out_green;
    logic [CHAN_W-1:0]  out_red;
    logic               matched;
    logic               frame_done;
    logic               found;
    logic [COORD_W-1:0] centroid_x;
    logic [COORD_W-1:0] centroid_y;
    logic               marker_ok;
  } res_t;

  typedef struct packed {
    logic [CHAN_W-1:0]   red_min;
    logic [CHAN_W-1:0]   green_max;
    logic [CHAN_W-1:0]   blue_max;
    logic [MARGIN_W-1:0] marker_margin;
    logic [SIZE_W-1:0]   frame_width;
    logic [SIZE_W-1:0]   frame_height;
  } cfg_t;

  typedef struct packed {
    logic accept;      // an input item is taken this cycle
    logic load_frame;  // that item ends the frame: load the divider
    logic step;        // run one divider step
    logic swap;        // last column step: keep x, load the row sum
    logic finish;      // last row step: write the centroid result
  } rpc_cmd_t;

  typedef struct packed {
    logic pix_last;    // frame_last of the offered item
  } rpc_stat_t;

endpackage

`default_nettype wire

// ===== rtl/core/rpc_pix_if.sv =====
// ----------------------------------------------------------------------------
// rpc_pix_if: pixel input channel
// Valid/ready channel that carries one pixel item.
// ----------------------------------------------------------------------------
`default_nettype none

interface rpc_pix_if import rpc_pkg::*; ();
  logic valid;
  logic ready;
  pix_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

`default_nettype wire

// ===== rtl/core/rpc_res_if.sv =====
// ----------------------------------------------------------------------------
// rpc_res_if: result output channel
// Valid/ready channel that carries one result item.
// ----------------------------------------------------------------------------
`default_nettype none

interface rpc_res_if import rpc_pkg::*; ();
  logic valid;
  logic ready;
  res_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

`default_nettype wire

// ===== rtl/core/rpc_cfg_if.sv =====
// ----------------------------------------------------------------------------
// rpc_cfg_if: configuration write channel
// Valid/ready channel that carries a register index and write data.
// ----------------------------------------------------------------------------
`default_nettype none

interface rpc_cfg_if import rpc_pkg::*; ();
  logic                  valid;
  logic                  ready;
  logic [CFG_IDX_W-1:0]  index;
  logic [CFG_DATA_W-1:0] data;

  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

`default_nettype wire

// ===== rtl/core/red_pixel_centroid.sv =====
// ----------------------------------------------------------------------------
// red_pixel_centroid: colour threshold blob centroid over a pixel stream
// Recolours matching pixels and reports their truncated mean position at the
// end of each frame.
// ----------------------------------------------------------------------------
`default_nettype none

// Each pixel item yields exactly one result item. A stream without frame ends
// runs at one item per clock while each result is taken at once, and a new
// pixel is taken in the same cycle that the previous result is taken. The
// pixel marked frame_last is accepted and then passes through the shared
// restoring divider, which produces one quotient bit per cycle, ten for the
// column mean and then ten for the row mean; the input is held off until the
// frame-end result stands in the output register. A pixel matches when red is
// above red_min and green and blue are below green_max and blue_max; it then
// leaves as pure green and is added to the sums, which stop growing once 2^20
// matches are counted. Configuration writes are always accepted at once (ready
// stays high) and take effect on the next pixel; indexes beyond the six
// registers are ignored.

module red_pixel_centroid import rpc_pkg::*; (
  input  wire logic clk_i,
  input  wire logic rst_ni,
  rpc_pix_if.sink   pix_i,
  rpc_res_if.source res_o,
  rpc_cfg_if.sink   cfg_i
);

  cfg_t      cfg;
  rpc_cmd_t  cmd;
  rpc_stat_t stat;
  logic      in_ready;
  logic      out_valid;
  res_t      res;

  // Threshold and window registers.
  rpc_cfg_regs u_cfg_regs (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .cfg_i  (cfg_i),
    .cfg_o  (cfg)
  );

  // Handshake control and divider sequencing.
  rpc_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (pix_i.valid),
    .in_ready_o  (in_ready),
    .out_valid_o (out_valid),
    .out_ready_i (res_o.ready),
    .stat_i      (stat),
    .cmd_o       (cmd)
  );

  // Colour test, sums, divider and the result register.
  rpc_dpath u_dpath (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .pix_i  (pix_i.data),
    .cfg_i  (cfg),
    .cmd_i  (cmd),
    .stat_o (stat),
    .res_o  (res)
  );

  assign pix_i.ready = in_ready;
  assign res_o.valid = out_valid;
  assign res_o.data  = res;

endmodule

`default_nettype wire

// ===== rtl/core/rpc_cfg_regs.sv =====
// ----------------------------------------------------------------------------
// rpc_cfg_regs: configuration register file
// Six threshold and window registers, written through the write channel.
// ----------------------------------------------------------------------------
`default_nettype none

module rpc_cfg_regs import rpc_pkg::*; (
  input  wire logic clk_i,
  input  wire logic rst_ni,
  rpc_cfg_if.sink   cfg_i,
  output cfg_t      cfg_o
);

  cfg_t cfg_q;

  // Writes are always taken; unknown indexes are dropped.
  assign cfg_i.ready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.red_min       <= RED_MIN_RST;
      cfg_q.green_max     <= GREEN_MAX_RST;
      cfg_q.blue_max      <= BLUE_MAX_RST;
      cfg_q.marker_margin <= MARGIN_RST;
      cfg_q.frame_width   <= WIDTH_RST;
      cfg_q.frame_height  <= HEIGHT_RST;
    end else if (cfg_i.valid) begin
      case (cfg_idx_e'(cfg_i.index))
        REG_RED_MIN:       cfg_q.red_min       <= cfg_i.data[CHAN_W-1:0];
        REG_GREEN_MAX:     cfg_q.green_max     <= cfg_i.data[CHAN_W-1:0];
        REG_BLUE_MAX:      cfg_q.blue_max      <= cfg_i.data[CHAN_W-1:0];
        REG_MARKER_MARGIN: cfg_q.marker_margin <= cfg_i.data[MARGIN_W-1:0];
        REG_FRAME_WIDTH:   cfg_q.frame_width   <= cfg_i.data[SIZE_W-1:0];
        REG_FRAME_HEIGHT:  cfg_q.frame_height  <= cfg_i.data[SIZE_W-1:0];
        default: ;
      endcase
    end
  end

  assign cfg_o = cfg_q;

endmodule

`default_nettype wire

// ===== rtl/core/rpc_dpath.sv =====
// ----------------------------------------------------------------------------
// rpc_dpath: colour test, accumulators, divider and result register
// Runs on commands from the controller; the divider is a shared restoring
// unit that makes one quotient bit per step, first for x and then for y.
// ----------------------------------------------------------------------------
`default_nettype none

module rpc_dpath import rpc_pkg::*; (
  input  wire logic clk_i,
  input  wire logic rst_ni,
  input  pix_t      pix_i,
  input  cfg_t      cfg_i,
  input  rpc_cmd_t  cmd_i,
  output rpc_stat_t stat_o,
  output res_t      res_o
);

  logic [SUM_W-1:0]   sum_col_q, sum_row_q;
  logic [CNT_W-1:0]   cnt_q;
  logic [SUM_W-1:0]   col_nxt, row_nxt;
  logic [CNT_W-1:0]   cnt_nxt;
  logic               hit, add;

  logic [DIV_W-1:0]   rem_q, dsh_q, rem_nxt;
  logic [SUM_W-1:0]   row_hold_q;
  logic [CNT_W-1:0]   cnt_hold_q;
  logic [COORD_W-1:0] quot_q, quot_nxt, cx_q;
  logic               ge;

  logic               found;
  logic [WIN_W-1:0]   cx_w, cy_w, mg_w;
  logic               ok;
  res_t               res_q;

  assign stat_o.pix_last = pix_i.frame_last;

  // Colour test and accumulation; the count saturates at the cap.
  assign hit = (pix_i.in_red > cfg_i.red_min) && (pix_i.in_green < cfg_i.green_max) &&
               (pix_i.in_blue < cfg_i.blue_max);
  assign add = hit && (cnt_q < CNT_W'(COUNT_CAP));
  assign col_nxt = add ? sum_col_q + SUM_W'(pix_i.pixel_x) : sum_col_q;
  assign row_nxt = add ? sum_row_q + SUM_W'(pix_i.pixel_y) : sum_row_q;
  assign cnt_nxt = add ? cnt_q + CNT_W'(1) : cnt_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sum_col_q <= '0;
      sum_row_q <= '0;
      cnt_q     <= '0;
    end else if (cmd_i.accept) begin
      if (cmd_i.load_frame) begin
        sum_col_q <= '0;
        sum_row_q <= '0;
        cnt_q     <= '0;
      end else begin
        sum_col_q <= col_nxt;
        sum_row_q <= row_nxt;
        cnt_q     <= cnt_nxt;
      end
    end
  end

  // Restoring divider step. The quotient always fits the coordinate width
  // because every summed coordinate is below 2^COORD_W.
  assign ge       = rem_q >= dsh_q;
  assign rem_nxt  = ge ? rem_q - dsh_q : rem_q;
  assign quot_nxt = {quot_q[COORD_W-2:0], ge};

  always_ff @(posedge clk_i) begin
    if (cmd_i.load_frame) begin
      rem_q      <= DIV_W'(col_nxt);
      row_hold_q <= row_nxt;
      cnt_hold_q <= cnt_nxt;
      dsh_q      <= {cnt_nxt, {(COORD_W-1){1'b0}}};
      quot_q     <= '0;
    end else if (cmd_i.step) begin
      if (cmd_i.swap) begin
        cx_q   <= quot_nxt;
        rem_q  <= DIV_W'(row_hold_q);
        dsh_q  <= {cnt_hold_q, {(COORD_W-1){1'b0}}};
        quot_q <= '0;
      end else begin
        rem_q  <= rem_nxt;
        dsh_q  <= dsh_q >> 1;
        quot_q <= quot_nxt;
      end
    end
  end

  // Marker window test on the finished centroid.
  assign found = cnt_hold_q != '0;
  assign cx_w  = WIN_W'(cx_q);
  assign cy_w  = WIN_W'(quot_nxt);
  assign mg_w  = WIN_W'(cfg_i.marker_margin);
  assign ok    = (cx_w > mg_w) && (cy_w > mg_w) &&
                 (cx_w < WIN_W'(cfg_i.frame_width) + mg_w) &&
                 (cy_w < WIN_W'(cfg_i.frame_height) + mg_w);

  always_ff @(posedge clk_i) begin
    if (cmd_i.accept) begin
      res_q.out_blue   <= hit ? CHAN_NONE : pix_i.in_blue;
      res_q.out_green  <= hit ? CHAN_FULL : pix_i.in_green;
      res_q.out_red    <= hit ? CHAN_NONE : pix_i.in_red;
      res_q.matched    <= hit;
      res_q.frame_done <= pix_i.frame_last;
      res_q.found      <= 1'b0;
      res_q.centroid_x <= '0;
      res_q.centroid_y <= '0;
      res_q.marker_ok  <= 1'b0;
    end else if (cmd_i.finish) begin
      res_q.found      <= found;
      res_q.centroid_x <= found ? cx_q : '0;
      res_q.centroid_y <= found ? quot_nxt : '0;
      res_q.marker_ok  <= found && ok;
    end
  end

  assign res_o = res_q;

`ifndef SYNTHESIS
  a_sums_clear: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.load_frame |=> (cnt_q == '0) && (sum_col_q == '0) && (sum_row_q == '0))
    else $error("accumulators not cleared after frame end");
  a_cnt_cap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= CNT_W'(COUNT_CAP))
    else $error("match count above cap");
`endif

endmodule

`default_nettype wire

// ===== rtl/core/rpc_ctrl.sv =====
// ----------------------------------------------------------------------------
// rpc_ctrl: controller of the red pixel centroid block
// Handles the pixel and result channel handshakes and sequences the divider at frame end.
// ----------------------------------------------------------------------------
`default_nettype none

module rpc_ctrl import rpc_pkg::*; (
  input  wire logic clk_i,
  input  wire logic rst_ni,
  input  wire logic in_valid_i,
  output logic      in_ready_o,
  output logic      out_valid_o,
  input  wire logic out_ready_i,
  input  rpc_stat_t stat_i,
  output rpc_cmd_t  cmd_o
);

  typedef enum logic [1:0] {
    S_RUN,
    S_DIVX,
    S_DIVY
  } state_e;

  state_e            state_q, state_d;
  logic [STEP_W-1:0] step_q, step_d;
  logic              out_valid_q, out_valid_d;
  logic              accept, last_step;

  // The result register may be refilled in the cycle it is drained.
  assign in_ready_o = (state_q == S_RUN) && (!out_valid_q || out_ready_i);
  assign accept     = in_valid_i && in_ready_o;
  assign last_step  = step_q == STEP_W'(DIV_STEPS - 1);

  assign cmd_o.accept     = accept;
  assign cmd_o.load_frame = accept && stat_i.pix_last;
  assign cmd_o.step       = state_q != S_RUN;
  assign cmd_o.swap       = (state_q == S_DIVX) && last_step;
  assign cmd_o.finish     = (state_q == S_DIVY) && last_step;

  always_comb begin
    state_d     = state_q;
    step_d      = step_q;
    out_valid_d = (out_valid_q && !out_ready_i) || (accept && !stat_i.pix_last) ||
                  cmd_o.finish;
    case (state_q)
      S_RUN: begin
        step_d = '0;
        if (cmd_o.load_frame) begin
          state_d = S_DIVX;
        end
      end
      S_DIVX: begin
        step_d = step_q + STEP_W'(1);
        if (last_step) begin
          step_d  = '0;
          state_d = S_DIVY;
        end
      end
      S_DIVY: begin
        step_d = step_q + STEP_W'(1);
        if (last_step) begin
          step_d  = '0;
          state_d = S_RUN;
        end
      end
      default: begin
        step_d  = '0;
        state_d = S_RUN;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_RUN;
      step_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      step_q      <= step_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign out_valid_o = out_valid_q;

`ifndef SYNTHESIS
  a_div_out_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.load_frame |=> !out_valid_q)
    else $error("result register busy while the divider runs");
  a_finish_valid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.finish |=> out_valid_q && (state_q == S_RUN))
    else $error("frame-end result not presented");
  a_swap_phase: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.swap |=> (state_q == S_DIVY) && (step_q == '0))
    else $error("divider did not move to the row phase");
`endif

endmodule

`default_nettype wire
